### rtl/ssca_pkg.sv
// shared types, constants and class tables of the slab size class allocator
package ssca_pkg;

   localparam int PAGE_BYTES           = 4096;
   localparam int NUM_PAGES            = 64;
   localparam int NUM_CLASSES          = 7;
   localparam int SMALLEST_CLASS_BYTES = 8;
   localparam int HEADER_BYTES         = 16;
   localparam int LINK_BYTES           = 4;
   localparam int MAX_CLASS_BYTES      = SMALLEST_CLASS_BYTES << (NUM_CLASSES - 1);

   localparam int MAX_SLOTS   = (PAGE_BYTES - HEADER_BYTES) / (SMALLEST_CLASS_BYTES + LINK_BYTES);
   localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
   localparam int PAGE_W      = $clog2(NUM_PAGES);
   localparam int NEXT_W      = PAGE_W + 1;
   localparam int SLOT_W      = $clog2(MAX_SLOTS + 1);
   localparam int CLS_W       = 3;
   localparam int LINK_ADDR_W = $clog2(NUM_PAGES * MAX_SLOTS);
   localparam int LINK_DEPTH  = NUM_PAGES * MAX_SLOTS;
   localparam int SZ_W        = 12;
   localparam int CB_W        = 12;
   localparam int WITHIN_W    = PAGE_SHIFT;
   localparam int RECIP_SHIFT = 20;
   localparam int RECIP_W     = 18;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam int SLOTS_0 = (PAGE_BYTES - HEADER_BYTES) / ((SMALLEST_CLASS_BYTES << 0) + LINK_BYTES);
   localparam int SLOTS_1 = (PAGE_BYTES - HEADER_BYTES) / ((SMALLEST_CLASS_BYTES << 1) + LINK_BYTES);
   localparam int SLOTS_2 = (PAGE_BYTES - HEADER_BYTES) / ((SMALLEST_CLASS_BYTES << 2) + LINK_BYTES);
   localparam int SLOTS_3 = (PAGE_BYTES - HEADER_BYTES) / ((SMALLEST_CLASS_BYTES << 3) + LINK_BYTES);
   localparam int SLOTS_4 = (PAGE_BYTES - HEADER_BYTES) / ((SMALLEST_CLASS_BYTES << 4) + LINK_BYTES);
   localparam int SLOTS_5 = (PAGE_BYTES - HEADER_BYTES) / ((SMALLEST_CLASS_BYTES << 5) + LINK_BYTES);
   localparam int SLOTS_6 = (PAGE_BYTES - HEADER_BYTES) / ((SMALLEST_CLASS_BYTES << 6) + LINK_BYTES);
   localparam int SLOTS_7 = (PAGE_BYTES - HEADER_BYTES) / ((SMALLEST_CLASS_BYTES << 7) + LINK_BYTES);

   localparam int RECIP_0 = (1 << RECIP_SHIFT) / ((SMALLEST_CLASS_BYTES << 0) + LINK_BYTES);
   localparam int RECIP_1 = (1 << RECIP_SHIFT) / ((SMALLEST_CLASS_BYTES << 1) + LINK_BYTES);
   localparam int RECIP_2 = (1 << RECIP_SHIFT) / ((SMALLEST_CLASS_BYTES << 2) + LINK_BYTES);
   localparam int RECIP_3 = (1 << RECIP_SHIFT) / ((SMALLEST_CLASS_BYTES << 3) + LINK_BYTES);
   localparam int RECIP_4 = (1 << RECIP_SHIFT) / ((SMALLEST_CLASS_BYTES << 4) + LINK_BYTES);
   localparam int RECIP_5 = (1 << RECIP_SHIFT) / ((SMALLEST_CLASS_BYTES << 5) + LINK_BYTES);
   localparam int RECIP_6 = (1 << RECIP_SHIFT) / ((SMALLEST_CLASS_BYTES << 6) + LINK_BYTES);
   localparam int RECIP_7 = (1 << RECIP_SHIFT) / ((SMALLEST_CLASS_BYTES << 7) + LINK_BYTES);

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_TOO_LARGE = 2'd1;
   localparam logic [1:0] ST_NO_PAGE   = 2'd2;
   localparam logic [1:0] ST_BAD_ADDR  = 2'd3;

   typedef struct packed {
      logic        op;
      logic [15:0] request_size;
      logic [31:0] free_address;
   } req_type;

   typedef struct packed {
      logic [31:0] buffer_address;
      logic [1:0]  status;
      logic [15:0] class_allocated;
      logic [15:0] class_free;
   } rsp_type;

   typedef struct packed {
      logic             op;
      logic             too_large;
      logic             null_free;
      logic [CLS_W-1:0] cls;
      logic [31:0]      offset;
   } work_type;

   typedef struct packed {
      logic [CLS_W-1:0]  owner;
      logic [SLOT_W-1:0] head;
   } page_info_type;

   function automatic logic [CB_W-1:0] class_bytes(input logic [CLS_W-1:0] c);
      return CB_W'(SMALLEST_CLASS_BYTES << c);
   endfunction

   function automatic logic [SZ_W-1:0] slot_bytes(input logic [CLS_W-1:0] c);
      return SZ_W'((SMALLEST_CLASS_BYTES << c) + LINK_BYTES);
   endfunction

   function automatic logic [SLOT_W-1:0] class_slots(input logic [CLS_W-1:0] c);
      logic [SLOT_W-1:0] n;
      case (c)
         3'd0:    n = SLOT_W'(SLOTS_0);
         3'd1:    n = SLOT_W'(SLOTS_1);
         3'd2:    n = SLOT_W'(SLOTS_2);
         3'd3:    n = SLOT_W'(SLOTS_3);
         3'd4:    n = SLOT_W'(SLOTS_4);
         3'd5:    n = SLOT_W'(SLOTS_5);
         3'd6:    n = SLOT_W'(SLOTS_6);
         default: n = SLOT_W'(SLOTS_7);
      endcase
      return n;
   endfunction

   function automatic logic [RECIP_W-1:0] class_recip(input logic [CLS_W-1:0] c);
      logic [RECIP_W-1:0] r;
      case (c)
         3'd0:    r = RECIP_W'(RECIP_0);
         3'd1:    r = RECIP_W'(RECIP_1);
         3'd2:    r = RECIP_W'(RECIP_2);
         3'd3:    r = RECIP_W'(RECIP_3);
         3'd4:    r = RECIP_W'(RECIP_4);
         3'd5:    r = RECIP_W'(RECIP_5);
         3'd6:    r = RECIP_W'(RECIP_6);
         default: r = RECIP_W'(RECIP_7);
      endcase
      return r;
   endfunction

endpackage

### rtl/slab_size_class_allocator_unit.sv
// slab allocator top level: base register, front classifier, queue and back sequencer
// free: FDIV1, FDIV2, FCHK in the back; null free, oversize and bad page answer from idle
// allocate: scan of the claimed pages (newest first, up to 64), then pop
// a page claim first writes one link per slot of the class (7 to 340), then BFIN
// synchronous reset; then an init pass builds pages 0..6, no request taken
// one request in the back at a time; a 4-entry queue and a result register decouple the ports
module slab_size_class_allocator_unit import ssca_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_payload,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data
);

   logic [31:0] page_base_ff;
   logic        init_busy;
   logic        push_valid, push_ready;
   work_type    push_data;
   logic        pop_valid, pop_ready;
   work_type    pop_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         page_base_ff <= 32'd0;
      end else if (csr_write_enable) begin
         page_base_ff <= csr_write_data;
      end
   end

   ssca_front u_front (
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .page_base   (page_base_ff),
      .init_busy   (init_busy),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_data   (push_data)
   );

   ssca_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   ssca_back u_back (
      .clock       (clock),
      .reset       (reset),
      .page_base   (page_base_ff),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_data    (pop_data),
      .init_busy   (init_busy),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

### rtl/ssca_front.sv
// request classification: size class, oversize, null free and pool offset
module ssca_front import ssca_pkg::*; (
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_payload,
   input  logic [31:0] page_base,
   input  logic        init_busy,
   output logic        push_valid,
   input  logic        push_ready,
   output work_type    push_data
);

   logic [CLS_W-1:0] cls;

   // smallest class that fits, size zero lands in class 0
   always_comb begin
      cls = CLS_W'(NUM_CLASSES - 1);
      for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
         if ({4'd0, class_bytes(CLS_W'(c))} >= req_payload.request_size) begin
            cls = CLS_W'(c);
         end
      end
   end

   assign req_ready  = push_ready && !init_busy;
   assign push_valid = req_valid && !init_busy;

   always_comb begin
      push_data.op        = req_payload.op;
      push_data.too_large = req_payload.request_size > 16'(MAX_CLASS_BYTES);
      push_data.null_free = req_payload.free_address == 32'd0;
      push_data.cls       = cls;
      push_data.offset    = req_payload.free_address - page_base;
   end

endmodule

### rtl/ssca_queue.sv
// short queue of classified requests between front and back
module ssca_queue import ssca_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  work_type push_data,
   output logic     pop_valid,
   input  logic     pop_ready,
   output work_type pop_data
);

   work_type          entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              push, pop;

   assign push_ready = count_ff != (QPTR_W + 1)'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/ssca_back.sv
// execution sequencer: page scan, page build, pop, free decode and result register
module ssca_back import ssca_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic [31:0] page_base,
   input  logic        pop_valid,
   output logic        pop_ready,
   input  work_type    pop_data,
   output logic        init_busy,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_payload
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SCAN  = 4'd1;
   localparam logic [3:0] S_BUILD = 4'd2;
   localparam logic [3:0] S_BFIN  = 4'd3;
   localparam logic [3:0] S_POP   = 4'd4;
   localparam logic [3:0] S_FDIV1 = 4'd5;
   localparam logic [3:0] S_FDIV2 = 4'd6;
   localparam logic [3:0] S_FCHK  = 4'd7;

   function automatic logic [15:0] sat_inc(input logic [15:0] a);
      return (a == 16'hFFFF) ? a : a + 16'd1;
   endfunction

   function automatic logic [15:0] sat_dec(input logic [15:0] a);
      return (a == 16'd0) ? a : a - 16'd1;
   endfunction

   function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [SLOT_W-1:0] n);
      logic [16:0] s;
      s = {1'b0, a} + 17'(n);
      return s[16] ? 16'hFFFF : s[15:0];
   endfunction

   logic [3:0]             state_ff, state_in;
   logic                   init_ff, init_in;
   logic [NEXT_W-1:0]      next_page_ff, next_page_in;
   logic [15:0]            alloc_cnt_ff [NUM_CLASSES];
   logic [15:0]            alloc_cnt_in [NUM_CLASSES];
   logic [15:0]            free_cnt_ff [NUM_CLASSES];
   logic [15:0]            free_cnt_in [NUM_CLASSES];
   logic [CLS_W-1:0]       cls_ff, cls_in;
   logic [31:0]            off_ff, off_in;
   logic [NEXT_W-1:0]      scan_ff, scan_in;
   logic                   rdv_ff, rdv_in;
   logic [PAGE_W-1:0]      rdp_ff, rdp_in;
   logic [PAGE_W-1:0]      pg_ff, pg_in;
   logic [SLOT_W-1:0]      hd_ff, hd_in;
   logic [SLOT_W-1:0]      bld_i_ff, bld_i_in;
   logic [LINK_ADDR_W-1:0] bld_base_ff, bld_base_in;
   logic [WITHIN_W-1:0]    q_ff, q_in;
   logic [WITHIN_W-1:0]    slot_ff, slot_in;
   logic                   rem_zero_ff, rem_zero_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   page_info_type          page_info_mem [NUM_PAGES];
   page_info_type          info_rd_ff;
   logic [SLOT_W-1:0]      link_mem [LINK_DEPTH];
   logic [SLOT_W-1:0]      link_rd_ff;

   logic [PAGE_W-1:0]      info_raddr, info_waddr;
   logic                   info_we;
   page_info_type          info_wdata;
   logic [LINK_ADDR_W-1:0] link_raddr, link_waddr;
   logic                   link_we;
   logic [SLOT_W-1:0]      link_wdata;

   logic                   out_free;
   logic [SLOT_W-1:0]      n_cur;
   logic [SZ_W-1:0]        sz_cur;
   logic [15:0]            a_cur, f_cur, a_new, f_new;
   logic [WITHIN_W-1:0]    page_off;
   logic [WITHIN_W+RECIP_W-1:0] prod_q;
   logic [WITHIN_W+SZ_W-1:0]    prod_r;
   logic [SZ_W:0]          rem;
   logic                   match;
   logic [PAGE_W-1:0]      scan_page;
   logic [19:0]            slot_off;

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign init_busy   = init_ff;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;
   assign pop_ready   = (state_ff == S_IDLE) && out_free;

   assign n_cur  = class_slots(cls_ff);
   assign sz_cur = slot_bytes(cls_ff);
   assign a_cur  = alloc_cnt_ff[cls_ff];
   assign f_cur  = free_cnt_ff[cls_ff];
   assign page_off = off_ff[WITHIN_W-1:0];
   assign match  = rdv_ff && (info_rd_ff.owner == cls_ff) && (info_rd_ff.head < n_cur);
   assign scan_page = PAGE_W'(scan_ff - 1'b1);

   always_comb begin
      state_in     = state_ff;
      init_in      = init_ff;
      next_page_in = next_page_ff;
      alloc_cnt_in = alloc_cnt_ff;
      free_cnt_in  = free_cnt_ff;
      cls_in       = cls_ff;
      off_in       = off_ff;
      scan_in      = scan_ff;
      rdv_in       = rdv_ff;
      rdp_in       = rdp_ff;
      pg_in        = pg_ff;
      hd_in        = hd_ff;
      bld_i_in     = bld_i_ff;
      bld_base_in  = bld_base_ff;
      q_in         = q_ff;
      slot_in      = slot_ff;
      rem_zero_in  = rem_zero_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      info_raddr   = pg_ff;
      info_waddr   = pg_ff;
      info_we      = 1'b0;
      info_wdata   = '{owner: cls_ff, head: link_rd_ff};
      link_raddr   = bld_base_ff;
      link_waddr   = bld_base_ff + LINK_ADDR_W'(bld_i_ff);
      link_we      = 1'b0;
      link_wdata   = bld_i_ff + 1'b1;
      a_new        = a_cur;
      f_new        = f_cur;
      prod_q       = page_off * class_recip(info_rd_ff.owner);
      prod_r       = q_ff * sz_cur;
      rem          = (SZ_W + 1)'({{SZ_W{1'b0}}, page_off} - prod_r);
      slot_off     = 20'(hd_ff * sz_cur);

      unique case (state_ff)
         S_IDLE: begin
            if (pop_valid && out_free) begin
               off_in = pop_data.offset;
               cls_in = pop_data.cls;
               if (pop_data.op == OP_ALLOC) begin
                  if (pop_data.too_large) begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '{32'd0, ST_TOO_LARGE, 16'd0, 16'd0};
                  end else begin
                     scan_in  = next_page_ff;
                     rdv_in   = 1'b0;
                     state_in = S_SCAN;
                  end
               end else if (pop_data.null_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '{32'd0, ST_OK, 16'd0, 16'd0};
               end else if (pop_data.offset[31:PAGE_SHIFT] >=
                            (32 - PAGE_SHIFT)'(next_page_ff)) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '{32'd0, ST_BAD_ADDR, 16'd0, 16'd0};
               end else begin
                  info_raddr = pop_data.offset[PAGE_SHIFT +: PAGE_W];
                  pg_in      = pop_data.offset[PAGE_SHIFT +: PAGE_W];
                  state_in   = S_FDIV1;
               end
            end
         end
         // newest page first, one owner read issued per cycle
         S_SCAN: begin
            if (match) begin
               pg_in      = rdp_ff;
               hd_in      = info_rd_ff.head;
               link_raddr = LINK_ADDR_W'(rdp_ff) * LINK_ADDR_W'(MAX_SLOTS)
                            + LINK_ADDR_W'(info_rd_ff.head);
               rdv_in     = 1'b0;
               state_in   = S_POP;
            end else if (scan_ff != '0) begin
               info_raddr = scan_page;
               rdv_in     = 1'b1;
               rdp_in     = scan_page;
               scan_in    = scan_ff - 1'b1;
            end else begin
               rdv_in = 1'b0;
               if (n_cur != '0 && next_page_ff < NEXT_W'(NUM_PAGES)) begin
                  pg_in        = PAGE_W'(next_page_ff);
                  next_page_in = next_page_ff + 1'b1;
                  bld_base_in  = LINK_ADDR_W'(next_page_ff) * LINK_ADDR_W'(MAX_SLOTS);
                  bld_i_in     = '0;
                  state_in     = S_BUILD;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '{32'd0, ST_NO_PAGE, a_cur, f_cur};
                  state_in     = S_IDLE;
               end
            end
         end
         // chain the page's slots in ascending order
         S_BUILD: begin
            link_we = n_cur != '0;
            if (n_cur == '0 || bld_i_ff + 1'b1 >= n_cur) begin
               state_in = S_BFIN;
            end else begin
               bld_i_in = bld_i_ff + 1'b1;
            end
         end
         S_BFIN: begin
            info_we    = 1'b1;
            info_wdata = '{owner: cls_ff, head: '0};
            if (init_ff) begin
               if (pg_ff == PAGE_W'(NUM_CLASSES - 1)) begin
                  init_in  = 1'b0;
                  state_in = S_IDLE;
               end else begin
                  pg_in       = pg_ff + 1'b1;
                  cls_in      = cls_ff + 1'b1;
                  bld_base_in = bld_base_ff + LINK_ADDR_W'(MAX_SLOTS);
                  bld_i_in    = '0;
                  state_in    = S_BUILD;
               end
            end else begin
               free_cnt_in[cls_ff] = sat_add(f_cur, n_cur);
               hd_in      = '0;
               link_raddr = bld_base_ff;
               state_in   = S_POP;
            end
         end
         S_POP: begin
            info_we    = 1'b1;
            info_wdata = '{owner: cls_ff, head: link_rd_ff};
            a_new = sat_inc(a_cur);
            f_new = sat_dec(f_cur);
            alloc_cnt_in[cls_ff] = a_new;
            free_cnt_in[cls_ff]  = f_new;
            rsp_valid_in = 1'b1;
            rsp_data_in  = '{page_base + (32'(pg_ff) << PAGE_SHIFT) + 32'(slot_off),
                             ST_OK, a_new, f_new};
            state_in = S_IDLE;
         end
         // slot index by reciprocal multiply, corrected in the next step
         S_FDIV1: begin
            cls_in   = info_rd_ff.owner;
            hd_in    = info_rd_ff.head;
            q_in     = WITHIN_W'(prod_q >> RECIP_SHIFT);
            state_in = S_FDIV2;
         end
         S_FDIV2: begin
            if (rem >= {1'b0, sz_cur}) begin
               slot_in     = q_ff + 1'b1;
               rem_zero_in = (rem - {1'b0, sz_cur}) == '0;
            end else begin
               slot_in     = q_ff;
               rem_zero_in = rem == '0;
            end
            state_in = S_FCHK;
         end
         S_FCHK: begin
            if ({1'b0, cls_ff} >= (CLS_W + 1)'(NUM_CLASSES) || !rem_zero_ff ||
                slot_ff >= WITHIN_W'(n_cur)) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{32'd0, ST_BAD_ADDR, 16'd0, 16'd0};
            end else begin
               link_we    = 1'b1;
               link_waddr = LINK_ADDR_W'(pg_ff) * LINK_ADDR_W'(MAX_SLOTS)
                            + LINK_ADDR_W'(slot_ff);
               link_wdata = hd_ff;
               info_we    = 1'b1;
               info_wdata = '{owner: cls_ff, head: SLOT_W'(slot_ff)};
               a_new = sat_dec(a_cur);
               f_new = sat_inc(f_cur);
               alloc_cnt_in[cls_ff] = a_new;
               free_cnt_in[cls_ff]  = f_new;
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{32'd0, ST_OK, a_new, f_new};
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_BUILD;
         init_ff      <= 1'b1;
         next_page_ff <= NEXT_W'(NUM_CLASSES);
         for (int c = 0; c < NUM_CLASSES; c++) begin
            alloc_cnt_ff[c] <= 16'd0;
            free_cnt_ff[c]  <= 16'(class_slots(CLS_W'(c)));
         end
         cls_ff       <= '0;
         pg_ff        <= '0;
         bld_i_ff     <= '0;
         bld_base_ff  <= '0;
         rdv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         next_page_ff <= next_page_in;
         alloc_cnt_ff <= alloc_cnt_in;
         free_cnt_ff  <= free_cnt_in;
         cls_ff       <= cls_in;
         pg_ff        <= pg_in;
         bld_i_ff     <= bld_i_in;
         bld_base_ff  <= bld_base_in;
         rdv_ff       <= rdv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      off_ff      <= off_in;
      scan_ff     <= scan_in;
      rdp_ff      <= rdp_in;
      hd_ff       <= hd_in;
      q_ff        <= q_in;
      slot_ff     <= slot_in;
      rem_zero_ff <= rem_zero_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (info_we) begin
         page_info_mem[info_waddr] <= info_wdata;
      end
      info_rd_ff <= page_info_mem[info_raddr];
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      link_rd_ff <= link_mem[link_raddr];
   end

endmodule

### dv/testbench.sv
// testbench for the slab size class allocator: directed, random, backpressure and pool exhaustion
module testbench;
   import ssca_pkg::*;

   localparam int CYCLE_LIMIT = 4000000;
   localparam int LINK_SIZE   = NUM_PAGES * MAX_SLOTS + 1;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_payload;
   logic        csr_write_enable = 1'b0;
   logic [31:0] csr_write_data = '0;

   slab_size_class_allocator_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow allocator state
   logic [31:0] pool_base;
   int          page_class [NUM_PAGES];
   int          page_head  [NUM_PAGES];
   int          slot_next  [LINK_SIZE];
   int          next_page;
   int          alloc_cnt  [NUM_CLASSES];
   int          free_cnt   [NUM_CLASSES];

   rsp_type     pending_rsp_q[$];
   logic [31:0] live_buf_q[$];
   int          error_count = 0;
   int          cycle_count = 0;
   int          send_gap_pct = 0;
   int          stall_pct = 0;
   int          hold_cycles = 0;

   function automatic int class_size(int c);
      return SMALLEST_CLASS_BYTES << c;
   endfunction

   function automatic int slots_per_page(int c);
      return (PAGE_BYTES - HEADER_BYTES) / (class_size(c) + LINK_BYTES);
   endfunction

   function automatic int sat_up(int v);
      return (v >= 65535) ? 65535 : v + 1;
   endfunction

   function automatic int sat_down(int v);
      return (v == 0) ? 0 : v - 1;
   endfunction

   function automatic void carve_page(int p, int c);
      int n;
      n = slots_per_page(c);
      for (int i = 0; i < n; i++) slot_next[p * MAX_SLOTS + i] = i + 1;
      page_head[p] = 0;
      page_class[p] = c;
      free_cnt[c] = (free_cnt[c] + n > 65535) ? 65535 : free_cnt[c] + n;
   endfunction

   function automatic void init_pool();
      pool_base = '0;
      foreach (page_class[i]) begin
         page_class[i] = 0;
         page_head[i] = 0;
      end
      foreach (slot_next[i]) slot_next[i] = 0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
         alloc_cnt[c] = 0;
         free_cnt[c] = 0;
      end
      for (int c = 0; c < NUM_CLASSES; c++) carve_page(c, c);
      next_page = NUM_CLASSES;
   endfunction

   function automatic rsp_type predict_allocation(req_type r);
      rsp_type     o;
      logic [31:0] off, in_page, sz, slot;
      int          c, n, p;
      bit          found;
      o = '0;
      if (r.op == OP_ALLOC) begin
         c = 0;
         while (c < NUM_CLASSES && class_size(c) < int'(r.request_size)) c++;
         if (c >= NUM_CLASSES) begin
            o.status = ST_TOO_LARGE;
         end else begin
            n = slots_per_page(c);
            p = next_page;
            found = 1'b0;
            while (p > 0 && !found) begin
               p--;
               if (page_class[p] == c && page_head[p] < n) found = 1'b1;
            end
            if (!found && n > 0 && next_page < NUM_PAGES) begin
               p = next_page;
               next_page++;
               carve_page(p, c);
               found = 1'b1;
            end
            if (found) begin
               slot = page_head[p];
               page_head[p] = slot_next[p * MAX_SLOTS + slot];
               alloc_cnt[c] = sat_up(alloc_cnt[c]);
               free_cnt[c] = sat_down(free_cnt[c]);
               o.buffer_address = pool_base + p * PAGE_BYTES + slot * (class_size(c) + LINK_BYTES);
            end else begin
               o.status = ST_NO_PAGE;
            end
            o.class_allocated = 16'(alloc_cnt[c]);
            o.class_free = 16'(free_cnt[c]);
         end
      end else if (r.free_address != 0) begin
         off = r.free_address - pool_base;
         if (off / PAGE_BYTES >= next_page) begin
            o.status = ST_BAD_ADDR;
         end else begin
            p = off / PAGE_BYTES;
            c = page_class[p];
            in_page = off % PAGE_BYTES;
            sz = class_size(c) + LINK_BYTES;
            slot = in_page / sz;
            if (c >= NUM_CLASSES || in_page % sz != 0 || slot >= slots_per_page(c)) begin
               o.status = ST_BAD_ADDR;
            end else begin
               slot_next[p * MAX_SLOTS + slot] = page_head[p];
               page_head[p] = slot;
               alloc_cnt[c] = sat_down(alloc_cnt[c]);
               free_cnt[c] = sat_up(free_cnt[c]);
               o.class_allocated = 16'(alloc_cnt[c]);
               o.class_free = 16'(free_cnt[c]);
            end
         end
      end
      return o;
   endfunction

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // receiver: long hold-off first, then random stalls
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         hold_cycles--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp_q.size() == 0) begin
            $error("unexpected result transfer %h", rsp_payload);
            error_count++;
         end else begin
            rsp_type e;
            e = pending_rsp_q.pop_front();
            if (rsp_payload.buffer_address !== e.buffer_address) begin
               $error("buffer_address expected %h actual %h", e.buffer_address,
                      rsp_payload.buffer_address);
               error_count++;
            end
            if (rsp_payload.status !== e.status) begin
               $error("status expected %0d actual %0d", e.status, rsp_payload.status);
               error_count++;
            end
            if (rsp_payload.class_allocated !== e.class_allocated) begin
               $error("class_allocated expected %0d actual %0d", e.class_allocated,
                      rsp_payload.class_allocated);
               error_count++;
            end
            if (rsp_payload.class_free !== e.class_free) begin
               $error("class_free expected %0d actual %0d", e.class_free,
                      rsp_payload.class_free);
               error_count++;
            end
         end
      end
   end

   task automatic set_idling(int tx, int rx);
      send_gap_pct = tx;
      stall_pct = rx;
   endtask

   task automatic send_request(logic op, logic [15:0] size, logic [31:0] addr);
      req_type r;
      rsp_type e;
      if (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      r.op = op;
      r.request_size = size;
      r.free_address = addr;
      req_valid <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
      e = predict_allocation(r);
      pending_rsp_q.push_back(e);
      if (op == OP_ALLOC && e.status == ST_OK) live_buf_q.push_back(e.buffer_address);
   endtask

   // drop valid and wait on the clock so the next drive lands in a later step
   task automatic stop_sending();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (pending_rsp_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_page_base(logic [31:0] v);
      stop_sending();
      wait_drained();
      repeat (10) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      pool_base = v;
      live_buf_q.delete();
   endtask

   function automatic logic [31:0] take_live_buffer();
      int i;
      logic [31:0] a;
      i = $urandom_range(live_buf_q.size() - 1);
      a = live_buf_q[i];
      live_buf_q.delete(i);
      return a;
   endfunction

   function automatic logic [31:0] random_free_address();
      int p, c, k;
      k = $urandom_range(99);
      if (live_buf_q.size() > 0 && k < 75) return take_live_buffer();
      p = $urandom_range(next_page - 1);
      c = page_class[p];
      if (k < 82) return pool_base + p * PAGE_BYTES +
                         $urandom_range(slots_per_page(c)) * (class_size(c) + LINK_BYTES);
      if (k < 88) return pool_base + p * PAGE_BYTES + $urandom_range(PAGE_BYTES - 1);
      if (k < 92) return pool_base + $urandom_range(NUM_PAGES + 4) * PAGE_BYTES;
      if (k < 95) return 32'h0;
      return $urandom;
   endfunction

   function automatic logic [15:0] random_size();
      int k;
      k = $urandom_range(99);
      if (k < 88) return 16'($urandom_range(MAX_CLASS_BYTES));
      if (k < 92) return 16'd0;
      if (k < 96) return 16'($urandom_range(65535, MAX_CLASS_BYTES + 1));
      return 16'hFFFF;
   endfunction

   task automatic test_directed();
      logic [31:0] first;
      set_idling(0, 0);
      send_request(OP_ALLOC, 16'd0, 32'hFFFFFFFF);
      first = live_buf_q[0];
      send_request(OP_ALLOC, 16'd8, $urandom);
      send_request(OP_ALLOC, 16'd9, $urandom);
      send_request(OP_ALLOC, 16'd17, $urandom);
      send_request(OP_ALLOC, 16'd33, $urandom);
      send_request(OP_ALLOC, 16'd65, $urandom);
      send_request(OP_ALLOC, 16'd129, $urandom);
      send_request(OP_ALLOC, 16'd257, $urandom);
      send_request(OP_ALLOC, 16'd512, $urandom);
      // oversize
      send_request(OP_ALLOC, 16'd513, 32'h0);
      send_request(OP_ALLOC, 16'hFFFF, 32'hFFFFFFFF);
      // null free ignores the size field
      send_request(OP_FREE, 16'hFFFF, 32'h0);
      // bad addresses: misaligned, unclaimed page, past the last slot, top of memory
      send_request(OP_FREE, 16'h0, first + 1);
      send_request(OP_FREE, 16'h0, pool_base + 40 * PAGE_BYTES);
      send_request(OP_FREE, 16'h0, pool_base + 6 * PAGE_BYTES + 7 * 516);
      send_request(OP_FREE, 16'hFFFF, 32'hFFFFFFFF);
      // first lies at address zero here, so these frees are null frees and the slot stays taken
      send_request(OP_FREE, 16'h0, first);
      send_request(OP_FREE, 16'h0, first);
      send_request(OP_ALLOC, 16'd3, 32'h0);
      send_request(OP_ALLOC, 16'd3, 32'h0);
      stop_sending();
   endtask

   task automatic test_random(int n, int tx, int rx);
      set_idling(tx, rx);
      repeat (n) begin
         if ($urandom_range(99) < 8) begin
            stop_sending();
            repeat ($urandom_range(30, 10)) @(posedge clock);
         end
         if (live_buf_q.size() > 120 || (live_buf_q.size() > 0 && $urandom_range(99) < 45))
            send_request(OP_FREE, 16'($urandom), random_free_address());
         else if ($urandom_range(99) < 90)
            send_request(OP_ALLOC, random_size(), $urandom);
         else
            send_request(OP_FREE, 16'($urandom), random_free_address());
      end
      stop_sending();
   endtask

   task automatic test_backpressure();
      set_idling(0, 0);
      hold_cycles = 400;
      repeat (20) send_request(OP_ALLOC, 16'($urandom_range(64)), $urandom);
      stop_sending();
      wait_drained();
      repeat (20) send_request(OP_FREE, 16'($urandom), random_free_address());
      stop_sending();
   endtask

   task automatic test_exhaustion();
      int no_page;
      set_idling(33, 33);
      no_page = 0;
      for (int i = 0; i < 500 && no_page < 6; i++) begin
         send_request(OP_ALLOC, 16'd512, $urandom);
         if (pending_rsp_q[$].status == ST_NO_PAGE) no_page++;
      end
      repeat (4) send_request(OP_ALLOC, 16'($urandom_range(8)), $urandom);
      repeat (10) send_request(OP_FREE, 16'($urandom), random_free_address());
      repeat (10) send_request(OP_ALLOC, random_size(), $urandom);
      stop_sending();
   endtask

   initial begin
      init_pool();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(300, 0, 0);
      write_page_base(32'hFFFFF000);
      test_random(300, 59, 0);
      test_backpressure();
      write_page_base($urandom);
      test_random(300, 0, 59);
      write_page_base(32'hFFFFFFFF);
      test_random(300, 33, 33);
      write_page_base(32'h0);
      test_exhaustion();
      wait_drained();
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

### sim.f
rtl/ssca_pkg.sv
rtl/ssca_front.sv
rtl/ssca_queue.sv
rtl/ssca_back.sv
rtl/slab_size_class_allocator_unit.sv
dv/testbench.sv
